/* rtl/dws_pkg.sv */
// Shared constants, register codes and pipeline types for the damped wave stencil core.
package dws_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int GW_W      = 11;
    localparam int GH_W      = 16;
    localparam int COEF_W    = 31;
    localparam int ROW_W     = 16;
    localparam int COL_OUT_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    // Fixed-point layout: bracket is Q.58, product Q.88, result Q.28
    localparam int FRAC_SHIFT = 60;
    localparam int ROUND_BIT  = 59;
    // The bracket is cut at this bit for the two partial products
    localparam int SPLIT      = 34;

    // Register reset values
    localparam logic [GW_W-1:0]   GRID_WIDTH_RST = GW_W'(512);
    localparam logic [GH_W-1:0]   GRID_HEIGHT_RST = GH_W'(512);
    localparam logic [COEF_W-1:0] COEF_X_RST = COEF_W'(2803769);
    localparam logic [COEF_W-1:0] COEF_Y_RST = COEF_W'(2803769);
    localparam logic [COEF_W-1:0] DAMP_PREV_RST = COEF_W'(1073736455);
    localparam logic [COEF_W-1:0] DENOM_RST = COEF_W'(1073736455);

    // Smallest grid side in use
    localparam int MIN_SIDE = 3;

    // Register indexes of the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_COEF_X      = 3'd2,
        REG_COEF_Y      = 3'd3,
        REG_DAMP_PREV   = 3'd4,
        REG_DENOM       = 3'd5
    } cfg_reg_t;

    // Per-cell control that rides along the arithmetic pipeline
    typedef struct packed {
        logic [ROW_W-1:0]     row;     // row of the incoming cell
        logic [COL_OUT_W-1:0] col;     // column, low bits
        logic                 has_a;   // result for the row above
        logic                 has_b;   // extra zero result for the last row
        logic                 zero_a;  // result for the row above is an edge cell
        logic                 done_b;  // extra result closes the grid
    } dws_ctl_t;

endpackage

/* rtl/dws_stream_if.sv */
// Valid/ready stream interfaces for incoming cells and outgoing results.
interface dws_cell_if #(
    parameter int SAMPLE_WIDTH = dws_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] curr_value;
    logic signed [SAMPLE_WIDTH-1:0] prev_value;

    modport source (output valid, output curr_value, output prev_value, input ready);
    modport sink   (input valid, input curr_value, input prev_value, output ready);
endinterface

interface dws_result_if #(
    parameter int SAMPLE_WIDTH = dws_pkg::SAMPLE_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_WIDTH-1:0]      next_value;
    logic [dws_pkg::ROW_W-1:0]           out_row;
    logic [dws_pkg::COL_OUT_W-1:0]       out_col;
    logic                                last_in_run;
    logic                                grid_done;

    modport source (output valid, output next_value, output out_row, output out_col,
                    output last_in_run, output grid_done, input ready);
    modport sink   (input valid, input next_value, input out_row, input out_col,
                    input last_in_run, input grid_done, output ready);
endinterface

/* rtl/dws_line_buf.sv */
// Raster position counters, three line buffers and the 3-cell window (stage 1).
module dws_line_buf #(
    parameter int MAX_WIDTH    = dws_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = dws_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] curr_value,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_value,
    input  logic [dws_pkg::GW_W-1:0]       grid_width,
    input  logic [dws_pkg::GH_W-1:0]       grid_height,
    output logic                           s1_valid,
    input  logic                           s1_ready,
    output dws_pkg::dws_ctl_t              s1_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] s1_west,
    output logic signed [SAMPLE_WIDTH-1:0] s1_mid,
    output logic signed [SAMPLE_WIDTH-1:0] s1_east,
    output logic signed [SAMPLE_WIDTH-1:0] s1_north,
    output logic signed [SAMPLE_WIDTH-1:0] s1_south,
    output logic signed [SAMPLE_WIDTH-1:0] s1_prev
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int MW_W  = $clog2(MAX_WIDTH + 1);
    localparam int WCW   = (MW_W > dws_pkg::GW_W) ? MW_W : dws_pkg::GW_W;
    localparam int ROW_W = dws_pkg::ROW_W;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             valid_reg, valid_next;
    logic [WCW-1:0]   width_use;
    logic [ROW_W-1:0] height_use;
    logic             last_col, last_row, accept;
    logic [CW-1:0]    rd_addr;
    dws_pkg::dws_ctl_t ctl_reg, ctl_next;

    logic signed [SAMPLE_WIDTH-1:0] center_mem [MAX_WIDTH];
    logic signed [SAMPLE_WIDTH-1:0] above_mem  [MAX_WIDTH];
    logic signed [SAMPLE_WIDTH-1:0] prev_mem   [MAX_WIDTH];

    logic signed [SAMPLE_WIDTH-1:0] center_rd_reg, above_rd_reg, prev_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] west_reg, mid_reg, cur_reg;

    // Clamp the grid size registers
    always_comb
    begin
        if (grid_width < dws_pkg::GW_W'(dws_pkg::MIN_SIDE))
            width_use = WCW'(dws_pkg::MIN_SIDE);
        else if (WCW'(grid_width) > WCW'(MAX_WIDTH))
            width_use = WCW'(MAX_WIDTH);
        else
            width_use = WCW'(grid_width);
        if (grid_height < ROW_W'(dws_pkg::MIN_SIDE))
            height_use = ROW_W'(dws_pkg::MIN_SIDE);
        else
            height_use = grid_height;
    end

    assign last_col = WCW'(col_reg) >= (width_use - WCW'(1));
    assign last_row = row_reg >= (height_use - ROW_W'(1));
    assign in_ready = !valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    // Prefetch the right neighbor; at the row end fetch column 0 for the next row
    assign rd_addr = last_col ? '0 : col_reg + CW'(1);

    // Position counters and result flags
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        if (s1_ready)
            valid_next = 1'b0;
        if (accept)
        begin
            valid_next = 1'b1;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        ctl_next.row    = row_reg;
        ctl_next.col    = dws_pkg::COL_OUT_W'(col_reg);
        ctl_next.has_a  = row_reg != '0;
        ctl_next.has_b  = last_row;
        ctl_next.zero_a = (row_reg == ROW_W'(1)) || (col_reg == '0) || last_col;
        ctl_next.done_b = last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    // Line buffers: read before write; above and previous read the same column, center the prefetch address
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            center_rd_reg       <= center_mem[rd_addr];
            center_mem[col_reg] <= curr_value;
            above_rd_reg        <= above_mem[col_reg];
            above_mem[col_reg]  <= center_rd_reg;
            prev_rd_reg         <= prev_mem[col_reg];
            prev_mem[col_reg]   <= prev_value;
        end
    end

    // Window and stage-1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            west_reg <= mid_reg;
            mid_reg  <= center_rd_reg;
            cur_reg  <= curr_value;
            ctl_reg  <= ctl_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_ctl   = ctl_reg;
    assign s1_west  = west_reg;
    assign s1_mid   = mid_reg;
    assign s1_east  = center_rd_reg;
    assign s1_north = above_rd_reg;
    assign s1_south = cur_reg;
    assign s1_prev  = prev_rd_reg;

endmodule

/* rtl/dws_arith.sv */
// Stencil arithmetic pipeline: Laplacians, coefficient products, bracket sum, denominator split.
module dws_arith #(
    parameter int SAMPLE_WIDTH = dws_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s1_valid,
    output logic                             s1_ready,
    input  dws_pkg::dws_ctl_t                s1_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]   s1_west,
    input  logic signed [SAMPLE_WIDTH-1:0]   s1_mid,
    input  logic signed [SAMPLE_WIDTH-1:0]   s1_east,
    input  logic signed [SAMPLE_WIDTH-1:0]   s1_north,
    input  logic signed [SAMPLE_WIDTH-1:0]   s1_south,
    input  logic signed [SAMPLE_WIDTH-1:0]   s1_prev,
    input  logic [dws_pkg::COEF_W-1:0]       coef_x,
    input  logic [dws_pkg::COEF_W-1:0]       coef_y,
    input  logic [dws_pkg::COEF_W-1:0]       damp_prev_coef,
    input  logic [dws_pkg::COEF_W-1:0]       denom_coef,
    output logic                             s5_valid,
    input  logic                             s5_ready,
    output dws_pkg::dws_ctl_t                s5_ctl,
    output logic signed [SAMPLE_WIDTH+32:0]  s5_prod_hi,
    output logic [dws_pkg::SPLIT+dws_pkg::COEF_W-1:0] s5_prod_lo
);
    localparam int S     = SAMPLE_WIDTH;
    localparam int LAP_W = S + 2;
    localparam int MU_W  = S + 31;
    localparam int MP_W  = S + 32;
    localparam int ML_W  = S + 34;
    localparam int SUM_W = S + 35;
    localparam int PH_W  = S + 33;
    localparam int PL_W  = dws_pkg::SPLIT + dws_pkg::COEF_W;

    logic rdy2, rdy3, rdy4, rdy5;
    logic s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    dws_pkg::dws_ctl_t s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg;

    logic signed [LAP_W-1:0] s2_lx_reg, s2_ly_reg;
    logic signed [S-1:0]     s2_u_reg, s2_p_reg;
    logic signed [MU_W-1:0]  s3_mu_reg;
    logic signed [MP_W-1:0]  s3_mp_reg;
    logic signed [ML_W-1:0]  s3_mx_reg, s3_my_reg;
    logic signed [SUM_W-1:0] s4_sum_reg;
    logic signed [PH_W-1:0]  s5_ph_reg;
    logic [PL_W-1:0]         s5_pl_reg;

    // Backpressure chain
    assign rdy5     = !s5_valid_reg || s5_ready;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign s1_ready = rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
                s2_valid_reg <= s1_valid;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                s4_valid_reg <= s3_valid_reg;
            if (rdy5)
                s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 2: second differences along x and y
    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid)
        begin
            s2_lx_reg  <= LAP_W'(s1_west) + LAP_W'(s1_east) - (LAP_W'(s1_mid) <<< 1);
            s2_ly_reg  <= LAP_W'(s1_north) + LAP_W'(s1_south) - (LAP_W'(s1_mid) <<< 1);
            s2_u_reg   <= s1_mid;
            s2_p_reg   <= s1_prev;
            s2_ctl_reg <= s1_ctl;
        end
    end

    // Stage 3: coefficient products, all Q.58
    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            s3_mu_reg  <= MU_W'(s2_u_reg) <<< 31;
            s3_mp_reg  <= s2_p_reg * $signed({1'b0, damp_prev_coef});
            s3_mx_reg  <= s2_lx_reg * $signed({1'b0, coef_x});
            s3_my_reg  <= s2_ly_reg * $signed({1'b0, coef_y});
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    // Stage 4: bracket sum
    always_ff @(posedge clk)
    begin
        if (rdy4 && s3_valid_reg)
        begin
            s4_sum_reg <= SUM_W'(s3_mu_reg) - SUM_W'(s3_mp_reg)
                        + SUM_W'(s3_mx_reg) + SUM_W'(s3_my_reg);
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    // Stage 5: bracket times denominator as two partial products
    always_ff @(posedge clk)
    begin
        if (rdy5 && s4_valid_reg)
        begin
            s5_ph_reg  <= $signed(s4_sum_reg[SUM_W-1:dws_pkg::SPLIT])
                        * $signed({1'b0, denom_coef});
            s5_pl_reg  <= s4_sum_reg[dws_pkg::SPLIT-1:0] * denom_coef;
            s5_ctl_reg <= s4_ctl_reg;
        end
    end

    assign s5_valid   = s5_valid_reg;
    assign s5_ctl     = s5_ctl_reg;
    assign s5_prod_hi = s5_ph_reg;
    assign s5_prod_lo = s5_pl_reg;

endmodule

/* rtl/dws_out.sv */
// Rounding, saturation and result beat sequencing with a registered output.
module dws_out #(
    parameter int SAMPLE_WIDTH = dws_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s5_valid,
    output logic                            s5_ready,
    input  dws_pkg::dws_ctl_t               s5_ctl,
    input  logic signed [SAMPLE_WIDTH+32:0] s5_prod_hi,
    input  logic [dws_pkg::SPLIT+dws_pkg::COEF_W-1:0] s5_prod_lo,
    dws_result_if.source                    results
);
    localparam int S      = SAMPLE_WIDTH;
    localparam int PROD_W = S + 67;
    localparam int Q_W    = PROD_W - dws_pkg::FRAC_SHIFT;

    logic signed [PROD_W-1:0] prod, rounded;
    logic signed [Q_W-1:0]    q;
    logic signed [S-1:0]      sat_value;
    logic                     in_range;
    logic                     slot_free, need_a, emit_now;
    logic                     phase_reg, phase_next;
    logic                     out_valid_reg, out_valid_next;

    logic signed [S-1:0]             value_reg, value_next;
    logic [dws_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [dws_pkg::COL_OUT_W-1:0]   col_reg;
    logic                            last_reg, last_next;
    logic                            done_reg, done_next;

    // Recombine, round half up to Q.28, saturate
    always_comb
    begin
        prod = (PROD_W'(s5_prod_hi) <<< dws_pkg::SPLIT)
             + PROD_W'($signed({1'b0, s5_prod_lo}));
        rounded = prod + (PROD_W'(1) <<< dws_pkg::ROUND_BIT);
        q = rounded[PROD_W-1:dws_pkg::FRAC_SHIFT];
        in_range = (&q[Q_W-1:S-1]) || !(|q[Q_W-1:S-1]);
        if (in_range)
            sat_value = q[S-1:0];
        else if (q[Q_W-1])
            sat_value = {1'b1, {(S-1){1'b0}}};
        else
            sat_value = {1'b0, {(S-1){1'b1}}};
    end

    // Beat sequencing: row-above result first, then the last-row zero
    assign slot_free = !out_valid_reg || results.ready;
    assign need_a    = s5_ctl.has_a && !phase_reg;
    assign emit_now  = s5_valid && slot_free && (need_a || s5_ctl.has_b);
    assign s5_ready  = (!s5_ctl.has_a && !s5_ctl.has_b)
                     || (slot_free && !(need_a && s5_ctl.has_b));

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        row_next       = row_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (results.ready)
            out_valid_next = 1'b0;
        if (emit_now)
        begin
            out_valid_next = 1'b1;
            if (need_a)
            begin
                value_next = s5_ctl.zero_a ? '0 : sat_value;
                row_next   = s5_ctl.row - dws_pkg::ROW_W'(1);
                last_next  = !s5_ctl.has_b;
                done_next  = 1'b0;
                phase_next = s5_ctl.has_b;
            end
            else
            begin
                value_next = '0;
                row_next   = s5_ctl.row;
                last_next  = 1'b1;
                done_next  = s5_ctl.done_b;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            value_reg <= value_next;
            row_reg   <= row_next;
            col_reg   <= s5_ctl.col;
            last_reg  <= last_next;
            done_reg  <= done_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.next_value  = value_reg;
    assign results.out_row     = row_reg;
    assign results.out_col     = col_reg;
    assign results.last_in_run = last_reg;
    assign results.grid_done   = done_reg;

endmodule

/* rtl/damped_wave_stencil_step_core.sv */
// Top level of the streaming 2D damped wave stencil step.
//
// Takes at most one grid cell per clock in raster order (current and previous value) and returns the
// next value of the cell one row above, from a 3-cell window over two current-row line
// buffers plus one previous-row line buffer, each MAX_WIDTH entries in block memory. The
// arithmetic runs through six register stages (window, second differences, coefficient
// multiplies, bracket sum, split denominator multiply, round/saturate into the output
// register); the window stage loads at the edge that takes a cell. Sustained rate is one
// cell per clock while the result port is ready; cells of the last row produce two result
// beats each (the row above and the row's own zero edge), and since the result port moves
// one beat per clock the input pauses for each such cell. Row 0 cells produce no result.
// Line buffers need no clearing after reset: the first row only writes them. Change
// configuration only while no cell is in flight.
module damped_wave_stencil_step_core #(
    parameter int MAX_WIDTH    = dws_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = dws_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    dws_cell_if.sink                           cells,
    dws_result_if.source                       results,
    input  logic                               cfg_we,
    input  logic [dws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dws_pkg::CFG_DATA_W-1:0]     cfg_data
);
    logic [dws_pkg::GW_W-1:0]   grid_width_reg;
    logic [dws_pkg::GH_W-1:0]   grid_height_reg;
    logic [dws_pkg::COEF_W-1:0] coef_x_reg, coef_y_reg, damp_prev_reg, denom_reg;

    logic                           s1_valid, s1_ready, s5_valid, s5_ready;
    dws_pkg::dws_ctl_t              s1_ctl, s5_ctl;
    logic signed [SAMPLE_WIDTH-1:0] s1_west, s1_mid, s1_east, s1_north, s1_south, s1_prev;
    logic signed [SAMPLE_WIDTH+32:0] s5_prod_hi;
    logic [dws_pkg::SPLIT+dws_pkg::COEF_W-1:0] s5_prod_lo;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= dws_pkg::GRID_WIDTH_RST;
            grid_height_reg <= dws_pkg::GRID_HEIGHT_RST;
            coef_x_reg      <= dws_pkg::COEF_X_RST;
            coef_y_reg      <= dws_pkg::COEF_Y_RST;
            damp_prev_reg   <= dws_pkg::DAMP_PREV_RST;
            denom_reg       <= dws_pkg::DENOM_RST;
        end
        else if (cfg_we)
        begin
            case (dws_pkg::cfg_reg_t'(cfg_index))
                dws_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[dws_pkg::GW_W-1:0];
                dws_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data[dws_pkg::GH_W-1:0];
                dws_pkg::REG_COEF_X:      coef_x_reg      <= cfg_data[dws_pkg::COEF_W-1:0];
                dws_pkg::REG_COEF_Y:      coef_y_reg      <= cfg_data[dws_pkg::COEF_W-1:0];
                dws_pkg::REG_DAMP_PREV:   damp_prev_reg   <= cfg_data[dws_pkg::COEF_W-1:0];
                dws_pkg::REG_DENOM:       denom_reg       <= cfg_data[dws_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    dws_line_buf #(
        .MAX_WIDTH    (MAX_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_line_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cells.valid),
        .in_ready    (cells.ready),
        .curr_value  (cells.curr_value),
        .prev_value  (cells.prev_value),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1_ctl      (s1_ctl),
        .s1_west     (s1_west),
        .s1_mid      (s1_mid),
        .s1_east     (s1_east),
        .s1_north    (s1_north),
        .s1_south    (s1_south),
        .s1_prev     (s1_prev)
    );

    dws_arith #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_arith (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid),
        .s1_ready       (s1_ready),
        .s1_ctl         (s1_ctl),
        .s1_west        (s1_west),
        .s1_mid         (s1_mid),
        .s1_east        (s1_east),
        .s1_north       (s1_north),
        .s1_south       (s1_south),
        .s1_prev        (s1_prev),
        .coef_x         (coef_x_reg),
        .coef_y         (coef_y_reg),
        .damp_prev_coef (damp_prev_reg),
        .denom_coef     (denom_reg),
        .s5_valid       (s5_valid),
        .s5_ready       (s5_ready),
        .s5_ctl         (s5_ctl),
        .s5_prod_hi     (s5_prod_hi),
        .s5_prod_lo     (s5_prod_lo)
    );

    dws_out #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .s5_valid   (s5_valid),
        .s5_ready   (s5_ready),
        .s5_ctl     (s5_ctl),
        .s5_prod_hi (s5_prod_hi),
        .s5_prod_lo (s5_prod_lo),
        .results    (results)
    );

endmodule

/* rtl/dws_checker.sv */
// Port-level checks on the result stream of the stencil core, bound to the top level.
module dws_checker #(
    parameter int SAMPLE_WIDTH = dws_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [SAMPLE_WIDTH-1:0]    next_value,
    input logic [dws_pkg::ROW_W-1:0]         out_row,
    input logic [dws_pkg::COL_OUT_W-1:0]     out_col,
    input logic                              last_in_run,
    input logic                              grid_done
);
    // A stalled result beat stays up
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result beat keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(next_value) && $stable(out_row)
            && $stable(out_col) && $stable(last_in_run) && $stable(grid_done))
        else $error("result payload changed while stalled");

    // The grid closes on the last row's zero beat
    a_grid_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grid_done |-> last_in_run && (next_value == '0))
        else $error("grid end beat is not a final zero beat");

    // Top row is an edge row and never the last row
    a_top_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_row == '0) |-> (next_value == '0) && last_in_run && !grid_done)
        else $error("top row result is not a lone zero");

endmodule

bind damped_wave_stencil_step_core dws_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .next_value  (results.next_value),
    .out_row     (results.out_row),
    .out_col     (results.out_col),
    .last_in_run (results.last_in_run),
    .grid_done   (results.grid_done)
);

/* sim/damped_wave_stencil_step_core_tb.sv */
// Testbench for the damped wave stencil core: random grids checked against a built-in predictor.
`timescale 1ns / 1ps

module damped_wave_stencil_step_core_tb;

    localparam int SW            = dws_pkg::SAMPLE_WIDTH_DEF;
    localparam int LINE_DEPTH    = dws_pkg::MAX_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 12;     // pipeline is 6 deep, row 0 cells give no beat
    localparam int STALL_LIMIT   = 2000;   // cycles with no beat on either side
    localparam int MAX_REPORTS   = 200;

    // One expected result beat
    typedef struct packed {
        logic [SW-1:0]                 value;
        logic [dws_pkg::ROW_W-1:0]     row;
        logic [dws_pkg::COL_OUT_W-1:0] col;
        logic                          last_in_run;
        logic                          grid_done;
    } stencil_out_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    dws_pkg::cfg_reg_t              cfg_index;
    logic [dws_pkg::CFG_DATA_W-1:0] cfg_data;

    dws_cell_if   #(.SAMPLE_WIDTH(SW)) cell_bus ();
    dws_result_if #(.SAMPLE_WIDTH(SW)) result_bus ();

    damped_wave_stencil_step_core #(
        .MAX_WIDTH    (LINE_DEPTH),
        .SAMPLE_WIDTH (SW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cells     (cell_bus),
        .results   (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register shadows
    logic [dws_pkg::GW_W-1:0]   grid_width_q  = dws_pkg::GRID_WIDTH_RST;
    logic [dws_pkg::GH_W-1:0]   grid_height_q = dws_pkg::GRID_HEIGHT_RST;
    logic [dws_pkg::COEF_W-1:0] coef_x_q      = dws_pkg::COEF_X_RST;
    logic [dws_pkg::COEF_W-1:0] coef_y_q      = dws_pkg::COEF_Y_RST;
    logic [dws_pkg::COEF_W-1:0] damp_q        = dws_pkg::DAMP_PREV_RST;
    logic [dws_pkg::COEF_W-1:0] denom_q       = dws_pkg::DENOM_RST;

    // Predictor state: two rows of current values, one row of previous values
    logic [SW-1:0] rows_above_mem  [0:LINE_DEPTH-1];
    logic [SW-1:0] rows_center_mem [0:LINE_DEPTH-1];
    logic [SW-1:0] rows_prev_mem   [0:LINE_DEPTH-1];
    logic [SW-1:0] tap_w = '0;
    logic [SW-1:0] tap_c = '0;
    logic [SW-1:0] tap_e = '0;
    int unsigned   in_row = 0;
    int unsigned   in_col = 0;

    stencil_out_t expected_results [$];
    int           mismatch_count = 0;
    int           cells_sent     = 0;
    int           gap_pct        = 0;
    int           stall_pct      = 0;
    int           stall_left     = 0;
    int           idle_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned used_width();
        int unsigned w;
        w = grid_width_q;
        if (w < dws_pkg::MIN_SIDE)
            w = dws_pkg::MIN_SIDE;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        return w;
    endfunction

    function automatic int unsigned used_height();
        return (grid_height_q < dws_pkg::MIN_SIDE) ? dws_pkg::MIN_SIDE : grid_height_q;
    endfunction

    // Exact bracket times denominator, round half up at Q.28, saturate
    function automatic logic [SW-1:0] damped_next(input logic signed [SW-1:0] w, u, e, n, s, p);
        logic signed [127:0] tw, tu, te, tn, ts, tp;
        logic signed [127:0] lap_x, lap_y, acc, q;
        tw = w;
        tu = u;
        te = e;
        tn = n;
        ts = s;
        tp = p;
        lap_x = tw - 2 * tu + te;
        lap_y = tn - 2 * tu + ts;
        acc = tu * 2 * (128'sd1 <<< 30)
            - tp * $signed({97'd0, damp_q})
            + lap_x * $signed({97'd0, coef_x_q})
            + lap_y * $signed({97'd0, coef_y_q});
        acc = acc * $signed({97'd0, denom_q}) + (128'sd1 <<< 59);
        q = acc >>> 60;
        if (q > 128'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        if (q < -128'sh8000_0000)
            return 32'h8000_0000;
        return q[SW-1:0];
    endfunction

    // Advance the predictor by one accepted cell and queue its result beats
    function automatic void predict_cell(input logic [SW-1:0] curr, prev);
        int unsigned   wd, ht, c, r;
        logic          at_last_col, at_last_row;
        logic [SW-1:0] prev_old, above;
        stencil_out_t  res;
        wd = used_width();
        ht = used_height();
        c  = in_col;
        r  = in_row;
        at_last_col = (c >= wd - 1);
        at_last_row = (r >= ht - 1);

        tap_w = tap_c;
        tap_c = rows_center_mem[c];
        tap_e = (c + 1 < wd) ? rows_center_mem[c + 1] : '0;
        prev_old = rows_prev_mem[c];
        above    = rows_above_mem[c];
        rows_above_mem[c]  = tap_c;
        rows_center_mem[c] = curr;
        rows_prev_mem[c]   = prev;

        // result for the row above; edge cells stay zero
        if (r >= 1)
        begin
            res.value = '0;
            if (r != 1 && c != 0 && !at_last_col)
                res.value = damped_next(tap_w, tap_c, tap_e, above, curr, prev_old);
            res.row         = dws_pkg::ROW_W'(r - 1);
            res.col         = dws_pkg::COL_OUT_W'(c);
            res.last_in_run = !at_last_row;
            res.grid_done   = 1'b0;
            expected_results.push_back(res);
        end
        // bottom row also emits its own zero row
        if (at_last_row)
        begin
            res.value       = '0;
            res.row         = dws_pkg::ROW_W'(r);
            res.col         = dws_pkg::COL_OUT_W'(c);
            res.last_in_run = 1'b1;
            res.grid_done   = at_last_col;
            expected_results.push_back(res);
        end

        if (at_last_col)
        begin
            in_col = 0;
            in_row = at_last_row ? 0 : ((r + 1) & 32'hFFFF);
        end
        else
            in_col = c + 1;
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        logic [SW-1:0] near_one;
        near_one = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4:    return $urandom();
            default: return near_one;
        endcase
    endfunction

    function automatic logic [dws_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2, 3:    return dws_pkg::COEF_W'($urandom_range(0, 32'h1000_0000));
            4:       return dws_pkg::COEF_W'($urandom());
            default: return dws_pkg::COEF_W'($urandom_range(32'h3000_0000, 32'h4000_0000));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 25;
            default: return 50;
        endcase
    endfunction

    // Send one cell; predict at the accepting edge
    task automatic send_cell(input logic [SW-1:0] curr, prev);
        int unsigned gap;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 4);
            cell_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_bus.valid      <= 1'b1;
        cell_bus.curr_value <= curr;
        cell_bus.prev_value <= prev;
        @(posedge clk);
        while (!cell_bus.ready)
            @(posedge clk);
        predict_cell(curr, prev);
        cells_sent++;
    endtask

    // Stop sending and let every expected beat arrive
    task automatic wait_drained();
        cell_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after its last write
    task automatic write_reg(input dws_pkg::cfg_reg_t idx,
                             input logic [dws_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            dws_pkg::REG_GRID_WIDTH:  grid_width_q  = data[dws_pkg::GW_W-1:0];
            dws_pkg::REG_GRID_HEIGHT: grid_height_q = data[dws_pkg::GH_W-1:0];
            dws_pkg::REG_COEF_X:      coef_x_q      = data[dws_pkg::COEF_W-1:0];
            dws_pkg::REG_COEF_Y:      coef_y_q      = data[dws_pkg::COEF_W-1:0];
            dws_pkg::REG_DAMP_PREV:   damp_q        = data[dws_pkg::COEF_W-1:0];
            dws_pkg::REG_DENOM:       denom_q       = data[dws_pkg::COEF_W-1:0];
            default: ;
        endcase
    endtask

    // Program all registers; unused upper bits of the size registers get junk
    task automatic program_regs(input int unsigned w_val, h_val,
                                input logic [dws_pkg::COEF_W-1:0] cx, cy, dp, dn);
        wait_drained();
        write_reg(dws_pkg::REG_GRID_WIDTH,  {20'($urandom()), dws_pkg::GW_W'(w_val)});
        write_reg(dws_pkg::REG_GRID_HEIGHT, {15'($urandom()), dws_pkg::GH_W'(h_val)});
        write_reg(dws_pkg::REG_COEF_X,      cx);
        write_reg(dws_pkg::REG_COEF_Y,      cy);
        write_reg(dws_pkg::REG_DAMP_PREV,   dp);
        write_reg(dws_pkg::REG_DENOM,       dn);
        cfg_we <= 1'b0;
    endtask

    // Mostly small grids, some clamped below, a few wider
    task automatic program_random_grid();
        int unsigned pick, wd, ht;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            wd = $urandom_range(3, 12);
        else if (pick < 17)
            wd = $urandom_range(0, 2);
        else
            wd = $urandom_range(13, 40);
        ht = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
        program_regs(wd, ht, pick_coef(), pick_coef(), pick_coef(), pick_coef());
    endtask

    // One whole grid of random cells, with an occasional drain mid-grid
    task automatic send_grid(input int hold_permille);
        repeat (used_width() * used_height())
        begin
            if ($urandom_range(0, 999) < hold_permille)
                wait_drained();
            send_cell(pick_sample(), pick_sample());
        end
    endtask

    // ---------------- tests ----------------

    // Sizes written, coefficients left at their reset values
    task automatic test_reset_coefs();
        wait_drained();
        write_reg(dws_pkg::REG_GRID_WIDTH,  dws_pkg::CFG_DATA_W'(3));
        write_reg(dws_pkg::REG_GRID_HEIGHT, dws_pkg::CFG_DATA_W'(3));
        cfg_we <= 1'b0;
        gap_pct   = 25;
        stall_pct = 25;
        send_grid(0);
    endtask

    // Sizes below the minimum, maximum coefficients, saturation both ways
    task automatic test_saturation_clamp();
        program_regs(0, 1, '1, '1, '1, '1);
        gap_pct   = 0;
        stall_pct = 30;
        repeat (9) send_cell(32'h7FFF_FFFF, 32'h8000_0000);
        repeat (9) send_cell(32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic test_random_grids(input int target);
        while (cells_sent < target)
        begin
            program_random_grid();
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
            send_grid(5);
        end
    endtask

    // Size registers changed in the middle of a grid
    task automatic test_mid_grid_changes();
        gap_pct   = 20;
        stall_pct = 20;
        program_regs(8, 16'hFFFF, pick_coef(), pick_coef(), pick_coef(), pick_coef());
        repeat (3 * 8 + 7) send_cell(pick_sample(), pick_sample());
        // column 7 now lies past the last column
        wait_drained();
        write_reg(dws_pkg::REG_GRID_WIDTH, dws_pkg::CFG_DATA_W'(5));
        cfg_we <= 1'b0;
        repeat (1 + 5 + 2) send_cell(pick_sample(), pick_sample());
        // row 5 now lies past the last row
        wait_drained();
        write_reg(dws_pkg::REG_GRID_HEIGHT, dws_pkg::CFG_DATA_W'(0));
        cfg_we <= 1'b0;
        repeat (3) send_cell(pick_sample(), pick_sample());

        // height raised while on the bottom row
        program_regs(4, 3, pick_coef(), pick_coef(), pick_coef(), pick_coef());
        repeat (4 * 2 + 2) send_cell(pick_sample(), pick_sample());
        wait_drained();
        write_reg(dws_pkg::REG_GRID_HEIGHT, dws_pkg::CFG_DATA_W'(5));
        cfg_we <= 1'b0;
        repeat (2 + 4 * 2) send_cell(pick_sample(), pick_sample());
    endtask

    // Width above the line depth: first row wraps at full depth, then narrows
    task automatic test_wide_row();
        gap_pct   = 5;
        stall_pct = 10;
        program_regs(2047, 3, pick_coef(), pick_coef(), pick_coef(), pick_coef());
        repeat (LINE_DEPTH) send_cell(pick_sample(), pick_sample());
        wait_drained();
        write_reg(dws_pkg::REG_GRID_WIDTH, dws_pkg::CFG_DATA_W'(5));
        cfg_we <= 1'b0;
        repeat (2 * 5) send_cell(pick_sample(), pick_sample());
    endtask

    // Back-to-back beats on both sides, one grid size throughout
    task automatic test_steady_stream(input int target);
        gap_pct   = 0;
        stall_pct = 0;
        program_random_grid();
        while (cells_sent < target)
            send_grid(0);
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= dws_pkg::REG_GRID_WIDTH;
        cfg_data            <= '0;
        cell_bus.valid      <= 1'b0;
        cell_bus.curr_value <= '0;
        cell_bus.prev_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_coefs();
        test_saturation_clamp();
        test_random_grids(200);
        test_mid_grid_changes();
        test_wide_row();
        test_steady_stream(cells_sent + 200);

        wait_drained();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Random result side backpressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_bus.ready <= 1'b0;
        end
        else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 3);
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= 1'b1;
    end

    task automatic report_field(input string name, input longint want_v, got_v);
        if (want_v != got_v)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        stencil_out_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected beat, expected none, actual row %0d col %0d value %0d",
                             $time, result_bus.out_row, result_bus.out_col,
                             result_bus.next_value);
            end
            else
            begin
                want = expected_results.pop_front();
                report_field("next_value", longint'($signed(want.value)),
                             longint'(result_bus.next_value));
                report_field("out_row", longint'(want.row), longint'(result_bus.out_row));
                report_field("out_col", longint'(want.col), longint'(result_bus.out_col));
                report_field("last_in_run", longint'(want.last_in_run),
                             longint'(result_bus.last_in_run));
                report_field("grid_done", longint'(want.grid_done),
                             longint'(result_bus.grid_done));
            end
        end
    end

    // Watchdog: too long without any beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (cell_bus.valid && cell_bus.ready) ||
            (result_bus.valid && result_bus.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
rtl/dws_pkg.sv
rtl/dws_stream_if.sv
rtl/dws_line_buf.sv
rtl/dws_arith.sv
rtl/dws_out.sv
rtl/damped_wave_stencil_step_core.sv
rtl/dws_checker.sv
sim/damped_wave_stencil_step_core_tb.sv
